### hdl/ucfc_pkg.sv
`timescale 1ns / 1ps

package ucfc_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 15;
  localparam int unsigned POS_W           = 6;
  localparam int unsigned REG_IDX_W       = 2;
  localparam int unsigned PAYLOAD_FIRST   = 6;
  localparam int unsigned PAYLOAD_LANES   = 8;
  localparam int unsigned FIRST_SUM_POS   = 2;
  localparam int unsigned ID_LOW_POS      = 3;
  localparam int unsigned ID_HIGH_POS     = 4;
  localparam int unsigned LENGTH_POS      = 5;
  localparam logic [7:0]  MAX_DLC         = 8'd8;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_LENGTH = 3'd1,
    ST_START  = 3'd2,
    ST_TYPE   = 3'd3,
    ST_DLC    = 3'd4,
    ST_SUM    = 3'd5
  } status_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_START_FIRST  = 2'd0,
    REG_START_SECOND = 2'd1,
    REG_COMMAND_TYPE = 2'd2
  } reg_idx_e;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_IDLE = 1'b1
  } op_e;

  typedef struct packed {
    logic [7:0] start_first;
    logic [7:0] start_second;
    logic [7:0] command_type;
  } cfg_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } item_t;

endpackage

### hdl/ucfc_in_if.sv
`timescale 1ns / 1ps

interface ucfc_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

### hdl/ucfc_out_if.sv
`timescale 1ns / 1ps

interface ucfc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] can_id;
  logic [3:0]  length_code;
  logic [63:0] payload;

  modport source (output valid, output status, output can_id, output length_code,
                  output payload, input ready);
  modport sink (input valid, input status, input can_id, input length_code,
                input payload, output ready);
endinterface

### hdl/ucfc_cfg_if.sv
`timescale 1ns / 1ps

interface ucfc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/ucfc_cfg_regs.sv
`timescale 1ns / 1ps

module ucfc_cfg_regs
  import ucfc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  ucfc_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_START_FIRST:  cfg_d.start_first  = cfg_i.data;
        REG_START_SECOND: cfg_d.start_second = cfg_i.data;
        REG_COMMAND_TYPE: cfg_d.command_type = cfg_i.data;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/ucfc_in_stage.sv
`timescale 1ns / 1ps

module ucfc_in_stage
  import ucfc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  ucfc_in_if.sink  in_i,
  output logic     item_valid_o,
  output item_t    item_o,
  input  logic     item_take_i
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  load;

  assign in_i.ready = !valid_q || item_take_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d        = 1'b1;
      item_d.opcode  = in_i.opcode;
      item_d.rx_byte = in_i.rx_byte;
    end else if (item_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### hdl/ucfc_check.sv
`timescale 1ns / 1ps

module ucfc_check
  import ucfc_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       item_valid_i,
  input  item_t      item_i,
  output logic       item_take_o,
  ucfc_out_if.source out_o
);

  localparam logic [POS_W-1:0] LastPos = POS_W'(FRAME_BYTES - 1);

  // chunk state
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       xor_q, xor_d;
  status_e          err_q, err_d;
  logic [15:0]      id_q, id_d;
  logic [7:0]       len_q, len_d;
  logic [63:0]      pay_q, pay_d;

  // result register
  logic        res_valid_q, res_valid_d;
  status_e     res_status_q, res_status_d;
  logic [15:0] res_id_q, res_id_d;
  logic [3:0]  res_len_q, res_len_d;
  logic [63:0] res_pay_q, res_pay_d;

  logic       take;
  logic       emit;
  status_e    emit_status;
  logic [7:0] b;

  assign take        = item_valid_i && (!res_valid_q || out_o.ready);
  assign item_take_o = take;
  assign b           = item_i.rx_byte;

  always_comb begin
    pos_d       = pos_q;
    xor_d       = xor_q;
    err_d       = err_q;
    id_d        = id_q;
    len_d       = len_q;
    pay_d       = pay_q;
    emit        = 1'b0;
    emit_status = ST_OK;

    if (op_e'(item_i.opcode) == OP_IDLE) begin
      if (pos_q != '0) begin
        emit        = 1'b1;
        emit_status = ST_LENGTH;
      end
    end else begin
      if (pos_q == POS_W'(0)) begin
        if (b != cfg_i.start_first && err_d == ST_OK) err_d = ST_START;
      end else if (pos_q == POS_W'(1)) begin
        if (b != cfg_i.start_second && err_d == ST_OK) err_d = ST_START;
      end else if (pos_q == POS_W'(FIRST_SUM_POS)) begin
        if (b != cfg_i.command_type && err_d == ST_OK) err_d = ST_TYPE;
      end else if (pos_q == POS_W'(ID_LOW_POS)) begin
        id_d[7:0] = b;
      end else if (pos_q == POS_W'(ID_HIGH_POS)) begin
        id_d[15:8] = b;
      end else if (pos_q == POS_W'(LENGTH_POS)) begin
        len_d = b;
        if (b > MAX_DLC && err_d == ST_OK) err_d = ST_DLC;
      end
      for (int i = 0; i < PAYLOAD_LANES; i++) begin
        if (pos_q == POS_W'(PAYLOAD_FIRST + i)) pay_d[8*i +: 8] = b;
      end

      if (pos_q == LastPos) begin
        if (b != xor_q && err_d == ST_OK) err_d = ST_SUM;
        emit        = 1'b1;
        emit_status = err_d;
      end else begin
        if (pos_q >= POS_W'(FIRST_SUM_POS)) xor_d = xor_q ^ b;
        pos_d = pos_q + POS_W'(1);
      end
    end

    res_valid_d  = res_valid_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_len_d    = res_len_q;
    res_pay_d    = res_pay_q;
    if (take) begin
      res_valid_d = emit;
      if (emit) begin
        res_status_d = emit_status;
        res_id_d     = id_d;
        res_len_d    = (len_d > MAX_DLC) ? MAX_DLC[3:0] : len_d[3:0];
        res_pay_d    = pay_d;
      end
    end else if (out_o.ready) begin
      res_valid_d = 1'b0;
    end

    // end of chunk starts a fresh one
    if (emit) begin
      pos_d = '0;
      xor_d = '0;
      err_d = ST_OK;
      id_d  = '0;
      len_d = '0;
      pay_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      xor_q       <= '0;
      err_q       <= ST_OK;
      id_q        <= '0;
      len_q       <= '0;
      pay_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (take) begin
        pos_q <= pos_d;
        xor_q <= xor_d;
        err_q <= err_d;
        id_q  <= id_d;
        len_q <= len_d;
        pay_q <= pay_d;
      end
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_len_q    <= res_len_d;
    res_pay_q    <= res_pay_d;
  end

  assign out_o.valid       = res_valid_q;
  assign out_o.status      = res_status_q;
  assign out_o.can_id      = res_id_q;
  assign out_o.length_code = res_len_q;
  assign out_o.payload     = res_pay_q;

endmodule

### hdl/uart_can_frame_checker.sv
`timescale 1ns / 1ps

// checks fixed-length uart command frames, one request per received byte
// in_i: opcode 0 carries rx_byte, opcode 1 reports that the line went idle
// out_o: one result per finished chunk with status, can_id, length_code, payload
// cfg_i: writes start bytes and command type (index 0..2, others ignored)
// a chunk ends after FRAME_BYTES bytes or on idle after a partial chunk;
// idle with nothing pending gives no result
// the byte or idle request that ends a chunk passes the input register, then
// the result register, before its result is valid
// throughput: one request per cycle while out_o is not stalled; the frame state
// and checks of one byte resolve combinationally between the two registers
// reset clears config registers, chunk state and both valid flags
// when out_o stalls, the result holds and the input register still takes one
// more request; in_i.ready drops only while both registers are full
module uart_can_frame_checker
  import ucfc_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ucfc_in_if.sink    in_i,
  ucfc_out_if.source out_o,
  ucfc_cfg_if.sink   cfg_i
);

  cfg_t  cfg;
  logic  item_valid;
  item_t item;
  logic  item_take;

  ucfc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  ucfc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  ucfc_check #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .out_o        (out_o)
  );

endmodule

### hdl/ucfc_checker.sv
`timescale 1ns / 1ps

module ucfc_checker
  import ucfc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  out_status_i,
  input logic [15:0] out_can_id_i,
  input logic [3:0]  out_length_code_i,
  input logic [63:0] out_payload_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i)
      && $stable(out_can_id_i) && $stable(out_length_code_i) && $stable(out_payload_i))
    else $error("stalled result changed");

  // a new result must be preceded by an accepted input request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without a request");

  // input never blocks while the result side drains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled with output ready");

  // status and length code stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_status_i <= ST_SUM && out_length_code_i <= MAX_DLC[3:0])
    else $error("result field out of range");

endmodule

bind uart_can_frame_checker ucfc_checker u_ucfc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_status_i      (out_o.status),
  .out_can_id_i      (out_o.can_id),
  .out_length_code_i (out_o.length_code),
  .out_payload_i     (out_o.payload)
);
